### design/sfd_pkg.sv
// shared types and constants for the serial frame deframer
// no dependencies; imported by sfd_front, sfd_back and serial_frame_deframer_xor
package sfd_pkg;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

  localparam logic [7:0]  GOOD_XOR      = 8'hFF;
  localparam logic [7:0]  OVERHEAD      = 8'd4;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // input word command codes
  localparam logic CMD_RX_BYTE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_e_t;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_ZERO_BYTE = 2'd1,
    OP_BYTE      = 2'd2
  } op_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] source_addr;
    logic [7:0] dest_addr;
    logic [7:0] frame_length;
    logic [7:0] checksum_byte;
    logic       frame_valid;
  } out_word_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // handshake between the command queue and the frame engine
  typedef struct packed {
    logic avail;
    cmd_t head;
  } cmd_link_t;

endpackage

### design/sfd_front.sv
// input side: classifies incoming words and holds them in a short command queue
// depends on sfd_pkg
module sfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  sfd_pkg::in_word_t in_data,
  output logic              in_full,
  output sfd_pkg::cmd_link_t cmd_link,
  input  logic              cmd_pop
);
  import sfd_pkg::*;

  cmd_t                 cmd_q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_PTR_W:0]   count_r, count_nxt;
  logic                 do_push, do_pop;
  cmd_t                 cmd_in;

  // classify the word
  always_comb begin
    cmd_in.data = in_data.rx_byte;
    if (in_data.command == CMD_TICK) begin
      cmd_in.op = OP_TICK;
    end else if (in_data.rx_byte == 8'd0) begin
      cmd_in.op = OP_ZERO_BYTE;
    end else begin
      cmd_in.op = OP_BYTE;
    end
  end

  assign in_full        = (count_r == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign do_push        = in_push && !in_full;
  assign cmd_link.avail = (count_r != '0);
  assign cmd_link.head  = cmd_q_r[rd_ptr_r];
  assign do_pop         = cmd_pop && cmd_link.avail;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### design/sfd_back.sv
// frame engine: phase tracking, checksum, timeout and the result queue
// depends on sfd_pkg
module sfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  sfd_pkg::cmd_link_t cmd_link,
  output logic               cmd_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output sfd_pkg::out_word_t out_data
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_DST  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  dst_r, dst_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] timeout_r;

  out_word_t            res_q_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] res_wr_r, res_rd_r;
  logic [RES_PTR_W:0]   res_cnt_r, res_cnt_nxt;
  logic                 res_room, res_push, res_pop;
  out_word_t            res;

  logic       abort;
  phase_t     ph_eff;
  logic [7:0] xor_new, cnt_inc, b;

  assign res_room = (res_cnt_r != (RES_PTR_W+1)'(RES_DEPTH));
  assign cmd_pop  = cmd_link.avail && res_room;
  assign b        = cmd_link.head.data;
  assign cnt_inc  = cnt_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    src_nxt     = src_r;
    len_nxt     = len_r;
    dst_nxt     = dst_r;
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    elapsed_nxt = elapsed_r;
    res_push    = 1'b0;
    res         = '0;
    abort       = 1'b0;
    ph_eff      = phase_r;
    xor_new     = xor_r ^ b;

    if (cmd_pop) begin
      if (cmd_link.head.op == OP_TICK) begin
        if (elapsed_r != ELAPSED_MAX) begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
      end else begin
        elapsed_nxt = '0;
        // stale partial frame: report with held fields, then restart from idle
        abort = (phase_r != PH_IDLE) && (elapsed_r > timeout_r);
        if (abort) begin
          res_push          = 1'b1;
          res.kind          = KIND_ABORT;
          res.source_addr   = src_r;
          res.dest_addr     = dst_r;
          res.frame_length  = len_r;
          ph_eff            = PH_IDLE;
          src_nxt           = '0;
          len_nxt           = '0;
          dst_nxt           = '0;
          cnt_nxt           = '0;
          xor_new           = b;
        end
        xor_nxt = xor_new;
        case (ph_eff)
          PH_IDLE: begin
            if (cmd_link.head.op == OP_BYTE) begin
              src_nxt   = b;
              len_nxt   = '0;
              dst_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_LEN;
            end else begin
              xor_nxt   = '0;
              phase_nxt = PH_IDLE;
            end
          end
          PH_LEN: begin
            len_nxt   = b;
            phase_nxt = PH_DST;
          end
          PH_DST: begin
            dst_nxt   = b;
            cnt_nxt   = '0;
            phase_nxt = (len_r > OVERHEAD) ? PH_DATA : PH_SUM;
          end
          PH_DATA: begin
            res_push          = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = b;
            res.payload_index = cnt_r;
            res.source_addr   = src_r;
            res.dest_addr     = dst_r;
            res.frame_length  = len_r;
            cnt_nxt           = cnt_inc;
            if (cnt_inc >= len_r - OVERHEAD) begin
              phase_nxt = PH_SUM;
            end
          end
          default: begin
            res_push          = 1'b1;
            res.kind          = KIND_END;
            res.source_addr   = src_r;
            res.dest_addr     = dst_r;
            res.frame_length  = len_r;
            res.checksum_byte = b;
            res.frame_valid   = (xor_new == GOOD_XOR);
            xor_nxt           = '0;
            phase_nxt         = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign out_empty = (res_cnt_r == '0);
  assign out_data  = res_q_r[res_rd_r];
  assign res_pop   = out_pop && !out_empty;

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (res_push && !res_pop) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
    end else if (!res_push && res_pop) begin
      res_cnt_nxt = res_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      src_r     <= '0;
      len_r     <= '0;
      dst_r     <= '0;
      cnt_r     <= '0;
      xor_r     <= '0;
      elapsed_r <= '0;
      timeout_r <= TIMEOUT_RESET;
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      src_r     <= src_nxt;
      len_r     <= len_nxt;
      dst_r     <= dst_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
      elapsed_r <= elapsed_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (res_push) begin
        res_wr_r <= res_wr_r + 1'b1;
      end
      if (res_pop) begin
        res_rd_r <= res_rd_r + 1'b1;
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[res_wr_r] <= res;
    end
  end

endmodule

### design/serial_frame_deframer_xor.sv
// top level of the serial frame deframer with xor checksum
// depends on sfd_pkg, sfd_front and sfd_back
//
// accepts one word per clock while in_full is low: a received bus byte or a one
// millisecond tick. a nonzero byte in idle opens a frame (source, length,
// destination, length-4 payload bytes when length exceeds 4, then a checksum
// byte). each payload byte comes out as a payload result with its index, the
// checksum byte as a frame-end result whose valid flag is set when the xor of
// all frame bytes is 0xff. when a byte arrives after more than timeout_ms ticks
// of silence in a partial frame, an abort result carries the old frame's fields
// and the byte then starts over from idle. a word gives zero or one result. the
// front queue registers each accepted word; the frame engine handles one word
// per cycle while the result queue has room; with pop held high the block
// sustains one word per clock. timeout_ms resets to 50 and is written through
// cfg_wr_en/cfg_wr_data, by the user only while the block is idle (not enforced).
module serial_frame_deframer_xor (
  input  logic               clk,
  input  logic               rst_n,
  // input queue side
  input  logic               in_push,
  input  sfd_pkg::in_word_t  in_data,
  output logic               in_full,
  // result queue side
  output logic               out_empty,
  input  logic               out_pop,
  output sfd_pkg::out_word_t out_data,
  // timeout register
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);
  import sfd_pkg::*;

  cmd_link_t cmd_link;
  logic      cmd_pop;

  // front: word classification and two-entry command queue
  sfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_link (cmd_link),
    .cmd_pop  (cmd_pop)
  );

  // back: frame state, checksum, timeout and two-entry result queue
  sfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_link    (cmd_link),
    .cmd_pop     (cmd_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule
